// ===== rtl/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lpmr_pkg;

  // Ring size in bytes; pointers wrap naturally, so this is a power of two.
  localparam int BUFFER_BYTES = 4096;
  localparam int PTR_W        = $clog2(BUFFER_BYTES);
  localparam int LEN_W        = 12;
  localparam int HDR_BYTES    = 4;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_MSG = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_QUERY  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WHDR,
    S_RHDR0,
    S_RHDR1,
    S_RHDR2,
    S_RBYTE,
    S_RDATA,
    S_FIN,
    S_RESP
  } lpmr_state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] msg_length;
    logic [LEN_W-1:0] out_limit;
    logic             peek;
  } lpmr_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] copied_length;
    logic [LEN_W-1:0] used_bytes;
    logic             has_message;
  } lpmr_result_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [PTR_W-1:0] raddr;
  } lpmr_mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/lpmr_ram.sv =====
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lpmr_core.sv =====
// ----------------------------------------------------------------------------
// lpmr_core
// Sequencer of the message ring: header writes, header fetches, byte reads
// and the ring pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module lpmr_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire lpmr_pkg::lpmr_item_t   item,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output lpmr_pkg::lpmr_result_t      res,
  output lpmr_pkg::lpmr_mem_req_t     mem_req,
  input  wire logic [7:0]             rd_data
);

  import lpmr_pkg::*;

  lpmr_state_t      state_r, state_nxt;
  lpmr_item_t       item_r, item_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] wcur_r, wcur_nxt;
  logic [LEN_W-1:0] wleft_r, wleft_nxt;
  logic             wdrop_r, wdrop_nxt;
  logic [PTR_W-1:0] rcur_r, rcur_nxt;
  logic [LEN_W-1:0] rmsg_r, rmsg_nxt;
  logic [LEN_W-1:0] rcopy_r, rcopy_nxt;
  logic             ractive_r, ractive_nxt;
  logic             rpeek_r, rpeek_nxt;
  logic [2:0]       widx_r, widx_nxt;
  logic [7:0]       hdr_lo_r, hdr_lo_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             bvalid_r, bvalid_nxt;
  logic             last_r, last_nxt;
  logic [LEN_W-1:0] copied_r, copied_nxt;

  logic [PTR_W-1:0] used;
  logic [PTR_W-1:0] free_bytes;
  logic [LEN_W-1:0] mlen;
  logic [LEN_W-1:0] wleft_dec;
  logic [7:0]       hdr_byte;

  assign used       = wp_r - rp_r;
  assign free_bytes = PTR_W'(BUFFER_BYTES - 1) - used;
  assign mlen       = {rd_data[3:0], hdr_lo_r};
  assign wleft_dec  = wleft_r - LEN_W'(1);

  // Header is little-endian; the upper two bytes are always zero.
  always_comb begin
    case (widx_r)
      3'd0:    hdr_byte = item_r.msg_length[7:0];
      3'd1:    hdr_byte = {4'd0, item_r.msg_length[LEN_W-1:8]};
      3'd4:    hdr_byte = item_r.data_byte;
      default: hdr_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rp_r      <= '0;
      wp_r      <= '0;
      wcur_r    <= '0;
      wleft_r   <= '0;
      wdrop_r   <= 1'b0;
      rcur_r    <= '0;
      rmsg_r    <= '0;
      rcopy_r   <= '0;
      ractive_r <= 1'b0;
      rpeek_r   <= 1'b0;
      widx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      rp_r      <= rp_nxt;
      wp_r      <= wp_nxt;
      wcur_r    <= wcur_nxt;
      wleft_r   <= wleft_nxt;
      wdrop_r   <= wdrop_nxt;
      rcur_r    <= rcur_nxt;
      rmsg_r    <= rmsg_nxt;
      rcopy_r   <= rcopy_nxt;
      ractive_r <= ractive_nxt;
      rpeek_r   <= rpeek_nxt;
      widx_r    <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    hdr_lo_r <= hdr_lo_nxt;
    status_r <= status_nxt;
    byte_r   <= byte_nxt;
    bvalid_r <= bvalid_nxt;
    last_r   <= last_nxt;
    copied_r <= copied_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    wcur_nxt    = wcur_r;
    wleft_nxt   = wleft_r;
    wdrop_nxt   = wdrop_r;
    rcur_nxt    = rcur_r;
    rmsg_nxt    = rmsg_r;
    rcopy_nxt   = rcopy_r;
    ractive_nxt = ractive_r;
    rpeek_nxt   = rpeek_r;
    widx_nxt    = widx_r;
    hdr_lo_nxt  = hdr_lo_r;
    status_nxt  = status_r;
    byte_nxt    = byte_r;
    bvalid_nxt  = bvalid_r;
    last_nxt    = last_r;
    copied_nxt  = copied_r;
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wcur_r;
    mem_req.wdata = item.data_byte;
    mem_req.raddr = rcur_r;

    case (state_r)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          item_nxt   = item;
          status_nxt = ST_OK;
          byte_nxt   = 8'd0;
          bvalid_nxt = 1'b0;
          last_nxt   = 1'b0;
          copied_nxt = '0;
          state_nxt  = S_RESP;
          if (item.kind == KIND_WRITE) begin
            if (wleft_r != '0) begin
              // Continuation of a message: store or discard this byte.
              wleft_nxt = wleft_dec;
              if (wdrop_r) begin
                status_nxt = ST_REJECT;
                if (wleft_dec == '0) begin
                  wdrop_nxt = 1'b0;
                end
              end else begin
                mem_req.we = 1'b1;
                wcur_nxt   = wcur_r + PTR_W'(1);
                if (wleft_dec == '0) begin
                  wp_nxt   = wcur_r + PTR_W'(1);
                  last_nxt = 1'b1;
                end
              end
            end else if ({1'b0, free_bytes} <
                         (LEN_W + 1)'(HDR_BYTES) + {1'b0, item.msg_length}) begin
              status_nxt = ST_REJECT;
              if (item.msg_length > LEN_W'(1)) begin
                wleft_nxt = item.msg_length - LEN_W'(1);
                wdrop_nxt = 1'b1;
              end
            end else begin
              wcur_nxt  = wp_r;
              widx_nxt  = '0;
              state_nxt = S_WHDR;
            end
          end else if (item.kind == KIND_READ) begin
            if (ractive_r) begin
              state_nxt = S_RBYTE;
            end else if (used == '0) begin
              // Whole messages only ever enter the ring, so any data means one waits.
              status_nxt = ST_NO_MSG;
            end else begin
              state_nxt = S_RHDR0;
            end
          end else begin
            status_nxt = ST_QUERY;
          end
        end
      end

      S_WHDR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = hdr_byte;
        wcur_nxt      = wcur_r + PTR_W'(1);
        widx_nxt      = widx_r + 3'd1;
        if ((widx_r == 3'd3 && item_r.msg_length == '0) || widx_r == 3'd4) begin
          if (item_r.msg_length > LEN_W'(1)) begin
            wleft_nxt = item_r.msg_length - LEN_W'(1);
          end else begin
            wleft_nxt = '0;
            wp_nxt    = wcur_r + PTR_W'(1);
            last_nxt  = 1'b1;
          end
          state_nxt = S_RESP;
        end
      end

      S_RHDR0: begin
        mem_req.raddr = rp_r;
        state_nxt     = S_RHDR1;
      end

      S_RHDR1: begin
        mem_req.raddr = rp_r + PTR_W'(1);
        hdr_lo_nxt    = rd_data;
        state_nxt     = S_RHDR2;
      end

      S_RHDR2: begin
        rcur_nxt    = rp_r + PTR_W'(HDR_BYTES);
        rmsg_nxt    = mlen;
        rcopy_nxt   = (mlen < item_r.out_limit) ? mlen : item_r.out_limit;
        rpeek_nxt   = item_r.peek;
        ractive_nxt = 1'b1;
        state_nxt   = S_RBYTE;
      end

      S_RBYTE: begin
        if (rcopy_r != '0) begin
          mem_req.raddr = rcur_r;
          rcur_nxt      = rcur_r + PTR_W'(1);
          rcopy_nxt     = rcopy_r - LEN_W'(1);
          rmsg_nxt      = rmsg_r - LEN_W'(1);
          state_nxt     = S_RDATA;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RDATA: begin
        byte_nxt   = rd_data;
        bvalid_nxt = 1'b1;
        state_nxt  = (rcopy_r == '0) ? S_FIN : S_RESP;
      end

      S_FIN: begin
        copied_nxt = LEN_W'(rcur_r - rp_r - PTR_W'(HDR_BYTES));
        if (!rpeek_r) begin
          rp_nxt = rcur_r + PTR_W'(rmsg_r);
        end
        ractive_nxt = 1'b0;
        rcopy_nxt   = '0;
        rmsg_nxt    = '0;
        rpeek_nxt   = 1'b0;
        last_nxt    = 1'b1;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status        = status_r;
    res.byte_out      = byte_r;
    res.byte_valid    = bvalid_r;
    res.last          = last_r;
    res.copied_length = copied_r;
    res.used_bytes    = LEN_W'(used);
    res.has_message   = (used != '0);
  end

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_message_ring_unit.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_unit
// Byte ring that stores whole length-prefixed messages.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel (valid/ready): kind 0 writes one message
// byte, kind 1 reads one byte of the head message, anything else queries
// status. Every item produces exactly one result on the out_ channel.
// The block works on one item at a time; the ring is a single byte-wide RAM
// with a registered read, and each item passes through these steps:
//   - a continuation write byte or a status query: straight to the result,
//   - the first byte of an accepted message: 4 header bytes, then the payload
//     byte, written one per cycle (no payload byte for an empty message),
//   - a read byte: a header fetch at the start of a message, the byte read,
//     and a finish step when the read finishes.
// A finished result sits in an output register, so the next item is taken
// while the previous result still waits for out_ready. A stalled receiver
// holds the block once one further result is ready behind the held one.
// Reset empties the ring at once; the RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_message_ring_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic [lpmr_pkg::LEN_W-1:0] in_msg_length,
  input  wire logic [lpmr_pkg::LEN_W-1:0] in_out_limit,
  input  wire logic                       in_peek,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_byte_out,
  output logic                            out_byte_valid,
  output logic                            out_last,
  output logic [lpmr_pkg::LEN_W-1:0]      out_copied_length,
  output logic [lpmr_pkg::LEN_W-1:0]      out_used_bytes,
  output logic                            out_has_message
);

  import lpmr_pkg::*;

  lpmr_item_t    item;
  lpmr_result_t  res;
  lpmr_result_t  out_r;
  lpmr_mem_req_t mem_req;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r;
  logic [7:0]    rd_data;

  assign item.kind       = in_kind;
  assign item.data_byte  = in_data_byte;
  assign item.msg_length = in_msg_length;
  assign item.out_limit  = in_out_limit;
  assign item.peek       = in_peek;

  lpmr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  lpmr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ring (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // Output register: loads whenever it is empty or its transfer completes.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_byte_out      = out_r.byte_out;
  assign out_byte_valid    = out_r.byte_valid;
  assign out_last          = out_r.last;
  assign out_copied_length = out_r.copied_length;
  assign out_used_bytes    = out_r.used_bytes;
  assign out_has_message   = out_r.has_message;

endmodule

`default_nettype wire
